[rtl/lpmr_pkg.sv]
// Package for the length-prefixed message ring: widths, function and status codes.
// Used by the top level and the checker; depends on nothing.
`default_nettype none
package lpmr_pkg;
  localparam int QUEUE_BYTES_DEF = 256;
  localparam int LEN_BYTES_DEF = 4;
  localparam int RESERVE_W = 7;
  localparam logic [RESERVE_W-1:0] RESERVE_RESET = 7'd8;

  localparam logic [2:0] FUNC_PUSH_START = 3'd0;
  localparam logic [2:0] FUNC_PUSH_DATA  = 3'd1;
  localparam logic [2:0] FUNC_POP        = 3'd2;
  localparam logic [2:0] FUNC_PEEK       = 3'd3;
  localparam logic [2:0] FUNC_DELETE     = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_DATA_ERR  = 3'd3;
  localparam logic [2:0] ST_LEN_ERR   = 3'd4;
  localparam logic [2:0] ST_BUF_SMALL = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  msg_bytes;
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

[rtl/lpmr_ram.sv]
// Byte ring store: one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module lpmr_ram #(
  parameter int DEPTH = 256,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/length_prefixed_message_ring.sv]
// Top level of the length-prefixed message ring: control sequencer and output register.
// Depends on lpmr_pkg and lpmr_ram.
//
// The ring is one byte-wide memory, so every byte moves in a cycle of its own. A push
// start writes the LEN_BYTES header bytes and then gives its result, and a push data item
// writes its bytes one by one and then gives its result. Pop and peek read the header and
// check it before the status item, then read and emit each word of up to eight bytes.
// Delete, a length error and a buffer that is too small answer after the header is read
// and checked; the other errors and an empty ring answer straight from idle. Results pass
// through a one-entry output register; the next input item is taken once the sequencer is
// idle again and that register is free.
`default_nettype none
module length_prefixed_message_ring #(
  parameter int QUEUE_BYTES = lpmr_pkg::QUEUE_BYTES_DEF,
  parameter int LEN_BYTES = lpmr_pkg::LEN_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [9:0]  msg_length,
  input  wire logic [63:0] data_word,
  input  wire logic [9:0]  buf_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       msg_bytes,
  output logic [63:0]      out_word,
  output logic [3:0]       byte_count,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);
  localparam int AW = $clog2(QUEUE_BYTES);
  localparam int CW = AW + 1;
  localparam int HW = (LEN_BYTES >= 4) ? 32 : 8 * LEN_BYTES;
  localparam int LW = (HW < 11) ? HW : 11;
  localparam logic [AW-1:0] LB_A = AW'(LEN_BYTES);
  localparam logic [CW-1:0] LB_C = CW'(LEN_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDRW = 3'd1;
  localparam logic [2:0] S_DATW = 3'd2;
  localparam logic [2:0] S_HDRR = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [AW-1:0] head, tail, wptr, addr;
  logic [9:0] remaining;
  logic push_active;
  logic [6:0] reserve;
  logic [2:0] cnt;
  logic [3:0] nbytes;
  logic [2:0] fsel;
  logic [9:0] blen;
  logic [63:0] word;
  logic [HW-1:0] hdr;
  logic [9:0] mlen, done;
  logic rd_pend;
  logic [AW-1:0] hdr_idx;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  lpmr_pkg::result_t res;
  logic res_valid;
  logic put_tog, take_tog;

  lpmr_ram #(.DEPTH(QUEUE_BYTES), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [AW-1:0] used_a;
  logic [CW-1:0] used;
  logic [CW+1:0] taken;
  logic [CW+1:0] free_sp;
  logic [HW:0] hdr_max;
  logic out_free;
  assign used_a = tail - head;
  assign used = {1'b0, used_a};
  assign taken = (CW+2)'(used) + (CW+2)'(reserve);
  assign free_sp = (taken >= (CW+2)'(QUEUE_BYTES)) ? '0 : (CW+2)'(QUEUE_BYTES) - taken;
  assign hdr_max = {1'b0, {HW{1'b1}}};
  assign out_free = !res_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign cfg_ready = 1'b1;

  // The output register holds an item while the load and unload toggles differ.
  assign res_valid = put_tog ^ take_tog;

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = word[7:0];
    raddr = addr;
    if (state == S_HDRW) begin
      we = 1'b1;
      wdata = hdr[7:0];
    end else if (state == S_DATW) begin
      we = 1'b1;
    end
  end

  task automatic put(input logic [2:0] st, input logic [7:0] mb, input logic [63:0] w,
                     input logic [3:0] bc, input logic lst);
    res.status <= st;
    res.msg_bytes <= mb;
    res.out_word <= w;
    res.byte_count <= bc;
    res.last <= lst;
    put_tog <= ~put_tog;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      take_tog <= 1'b0;
    end else if (res_valid && !out_stall) begin
      take_tog <= ~take_tog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tail <= '0;
      wptr <= '0;
      remaining <= '0;
      push_active <= 1'b0;
      reserve <= lpmr_pkg::RESERVE_RESET;
      put_tog <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_valid) begin
        reserve <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && out_free) begin
            fsel <= func;
            blen <= buf_length;
            unique case (func) inside
              lpmr_pkg::FUNC_PUSH_START: begin
                if (msg_length == '0 || (HW+1)'(msg_length) > hdr_max) begin
                  put(lpmr_pkg::ST_INVALID, '0, '0, '0, 1'b1);
                end else if (free_sp < (CW+2)'(msg_length) + (CW+2)'(LEN_BYTES)) begin
                  put(lpmr_pkg::ST_NO_SPACE, '0, '0, '0, 1'b1);
                end else begin
                  hdr <= HW'(msg_length);
                  addr <= tail;
                  cnt <= '0;
                  remaining <= msg_length;
                  push_active <= 1'b0;
                  state <= S_HDRW;
                end
              end
              lpmr_pkg::FUNC_PUSH_DATA: begin
                if (!push_active) begin
                  put(lpmr_pkg::ST_INVALID, '0, '0, '0, 1'b1);
                end else begin
                  word <= data_word;
                  addr <= wptr;
                  nbytes <= (remaining < 10'd8) ? remaining[3:0] : 4'd8;
                  cnt <= '0;
                  state <= S_DATW;
                end
              end
              lpmr_pkg::FUNC_POP, lpmr_pkg::FUNC_PEEK, lpmr_pkg::FUNC_DELETE: begin
                if (func != lpmr_pkg::FUNC_DELETE && buf_length == '0) begin
                  put(lpmr_pkg::ST_INVALID, '0, '0, '0, 1'b1);
                end else if (used == '0) begin
                  put(lpmr_pkg::ST_OK, '0, '0, '0, 1'b1);
                end else if (used <= LB_C) begin
                  head <= tail;
                  put(lpmr_pkg::ST_DATA_ERR, '0, '0, '0, 1'b1);
                end else begin
                  addr <= head;
                  hdr <= '0;
                  hdr_idx <= '0;
                  rd_pend <= 1'b0;
                  state <= S_HDRR;
                end
              end
              default: put(lpmr_pkg::ST_INVALID, '0, '0, '0, 1'b1);
            endcase
          end
        end
        S_HDRW: begin
          hdr <= hdr >> 8;
          addr <= addr + 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == 3'(LEN_BYTES - 1)) begin
            wptr <= addr + 1'b1;
            push_active <= 1'b1;
            put(lpmr_pkg::ST_OK, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end
        end
        S_DATW: begin
          word <= word >> 8;
          addr <= addr + 1'b1;
          cnt <= cnt + 1'b1;
          if ({1'b0, cnt} == nbytes - 4'd1) begin
            wptr <= addr + 1'b1;
            remaining <= remaining - 10'(nbytes);
            if (remaining == 10'(nbytes)) begin
              tail <= addr + 1'b1;
              push_active <= 1'b0;
            end
            put(lpmr_pkg::ST_OK, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end
        end
        S_HDRR: begin
          // The read issued last cycle returns now; bytes arrive low byte first.
          if (rd_pend) begin
            hdr <= (hdr >> 8) | (HW'(rdata) << (HW - 8));
            hdr_idx <= hdr_idx + 1'b1;
            if (hdr_idx == LB_A - 1'b1) begin
              state <= S_CHK;
            end
          end
          if (!rd_pend || hdr_idx != LB_A - 1'b1) begin
            addr <= addr + 1'b1;
          end
          rd_pend <= 1'b1;
        end
        S_CHK: begin
          // addr now points at the first message byte.
          if (out_free) begin
            if (hdr == '0 || (HW+1)'(hdr) > (HW+1)'(used - LB_C)) begin
              head <= tail;
              put(lpmr_pkg::ST_LEN_ERR, '0, '0, '0, 1'b1);
              state <= S_IDLE;
            end else if (fsel == lpmr_pkg::FUNC_DELETE) begin
              head <= addr + AW'(hdr[LW-1:0]);
              put(lpmr_pkg::ST_OK, hdr[7:0], '0, '0, 1'b1);
              state <= S_IDLE;
            end else if ((HW+1)'(hdr) > (HW+1)'(blen)) begin
              put(lpmr_pkg::ST_BUF_SMALL, hdr[7:0], '0, '0, 1'b1);
              state <= S_IDLE;
            end else begin
              put(lpmr_pkg::ST_OK, hdr[7:0], '0, '0, 1'b0);
              mlen <= 10'(hdr[LW-1:0]);
              done <= '0;
              word <= '0;
              cnt <= '0;
              rd_pend <= 1'b0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (!rd_pend) begin
            addr <= addr + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            word <= word | (64'(rdata) << {cnt, 3'b000});
            cnt <= cnt + 1'b1;
            done <= done + 10'd1;
            if (cnt == 3'd7 || done + 10'd1 == mlen) begin
              state <= S_EMIT;
            end else begin
              addr <= addr + 1'b1;
            end
            rd_pend <= !(cnt == 3'd7 || done + 10'd1 == mlen);
          end
        end
        S_EMIT: begin
          // addr already points at the byte after the last one read.
          if (out_free) begin
            put(lpmr_pkg::ST_OK, mlen[7:0], word, {1'b0, cnt} + (cnt == 3'd0 ? 4'd8 : 4'd0),
                done == mlen);
            word <= '0;
            cnt <= '0;
            rd_pend <= 1'b0;
            if (done == mlen) begin
              if (fsel == lpmr_pkg::FUNC_POP) begin
                head <= addr;
              end
              state <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = res_valid;
  assign status = res.status;
  assign msg_bytes = res.msg_bytes;
  assign out_word = res.out_word;
  assign byte_count = res.byte_count;
  assign last = res.last;
endmodule
`default_nettype wire

[rtl/lpmr_checker.sv]
// Port-level checks for the length-prefixed message ring, bound to the top level.
// Depends on lpmr_pkg.
`default_nettype none
module lpmr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [63:0] out_word,
  input wire logic [3:0]  byte_count,
  input wire logic        last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(last))
    else $error("stalled result changed");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 4'd8)
    else $error("byte count out of range");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lpmr_pkg::ST_OK |-> last && byte_count == 4'd0)
    else $error("error result not final");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input accepted mid message");
endmodule

bind length_prefixed_message_ring lpmr_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .out_word(out_word), .byte_count(byte_count), .last(last)
);
`default_nettype wire
